FILE: rtl/lgcp_pkg.sv
// shared types, codes and tables of the led grid command parser
`timescale 1ns / 1ps
`default_nettype none

package lgcp_pkg;

	localparam int MAX_PACKET_DEF = 9;
	localparam int NUM_COLS       = 8;
	localparam int NUM_QUADS      = 4;
	localparam int COL_W          = $clog2(NUM_COLS);
	localparam int WORD_W         = 8 * NUM_QUADS;

	localparam logic [7:0] TIMEOUT_RST = 8'd40;
	localparam logic [7:0] VERSION_RST = 8'd0;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_VERSION = 2'd1;

	// input commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// packet types
	localparam logic [3:0] PT_LED_ON    = 4'd2;
	localparam logic [3:0] PT_LED_OFF   = 4'd3;
	localparam logic [3:0] PT_ROW       = 4'd4;
	localparam logic [3:0] PT_COL       = 4'd5;
	localparam logic [3:0] PT_ROW2      = 4'd6;
	localparam logic [3:0] PT_COL2      = 4'd7;
	localparam logic [3:0] PT_FRAME     = 4'd8;
	localparam logic [3:0] PT_CLEAR     = 4'd9;
	localparam logic [3:0] PT_INTENSITY = 4'd10;
	localparam logic [3:0] PT_MODE      = 4'd11;
	localparam logic [3:0] PT_GRIDS     = 4'd12;
	localparam logic [3:0] PT_AUX_IN    = 4'd13;
	localparam logic [3:0] PT_IGNORE    = 4'd15;

	// result kinds
	localparam logic [2:0] KIND_COLUMN  = 3'd0;
	localparam logic [2:0] KIND_BCAST   = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_GRIDS   = 3'd3;
	localparam logic [2:0] KIND_PORT    = 3'd4;

	// driver registers
	localparam logic [3:0] REG_NONE      = 4'd0;
	localparam logic [3:0] REG_INTENSITY = 4'd10;
	localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
	localparam logic [3:0] REG_TEST      = 4'd15;

	// mode and aux selectors
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_TEST   = 2'd1;
	localparam logic [1:0] MODE_OFF    = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;
	localparam logic [3:0] AUX_VERSION = 4'd0;
	localparam logic [3:0] AUX_PORT    = 4'd1;

	localparam logic [7:0] REPLY_HDR = 8'hE0;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOAD,
		ST_DISPATCH,
		ST_COLS,
		ST_MISC
	} eng_state_t;

	typedef struct packed {
		logic       done;
		logic [3:0] ptype;
		logic [3:0] length;
	} pkt_info_t;

	function automatic logic [3:0] pkt_len_lookup(input logic [3:0] ptype);
		logic [3:0] len;
		case (ptype)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: len = 4'd2;
			4'd6, 4'd7, 4'd13, 4'd14:           len = 4'd3;
			4'd8:                               len = 4'd9;
			4'd9, 4'd10, 4'd11, 4'd12:          len = 4'd1;
			default:                            len = 4'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lgcp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lgcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lgcp_assembler.sv
// packet framing: byte counting, idle timeout and packet buffer writes
`timescale 1ns / 1ps
`default_nettype none

module lgcp_assembler import lgcp_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          command,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    timeout_limit,
	output logic                          pkt_we,
	output logic [$clog2(MAX_PACKET)-1:0] pkt_waddr,
	output logic [7:0]                    pkt_wdata,
	output pkt_info_t                     pkt
);

	logic [3:0] byte_count_q;
	logic [3:0] expected_length_q;
	logic [3:0] packet_type_q;
	logic [8:0] idle_ticks_q;

	logic       is_byte;
	logic       is_tick;
	logic       begin_pkt;
	logic       complete;
	logic [3:0] type_in;
	logic [3:0] type_d;
	logic [3:0] len_d;
	logic [3:0] count_d;

	assign is_byte = accept && (command == CMD_BYTE);
	assign is_tick = accept && (command == CMD_TICK);
	assign type_in = data_byte[7:4];

	always_comb begin
		begin_pkt = 1'b0;
		type_d    = packet_type_q;
		len_d     = expected_length_q;
		count_d   = byte_count_q + 4'd1;
		if (byte_count_q == 4'd0) begin
			type_d = type_in;
			if (type_in != PT_IGNORE) begin
				begin_pkt = 1'b1;
				len_d     = pkt_len_lookup(type_in);
				count_d   = 4'd1;
			end else begin
				count_d = 4'd0;
			end
		end
	end

	assign complete   = is_byte && (count_d == len_d);
	assign pkt.done   = complete;
	assign pkt.ptype  = type_d;
	assign pkt.length = len_d;

	assign pkt_we    = is_byte && (int'(byte_count_q) < MAX_PACKET);
	assign pkt_waddr = byte_count_q[$clog2(MAX_PACKET)-1:0];
	assign pkt_wdata = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= 4'd0;
			expected_length_q <= 4'd1;
			packet_type_q     <= 4'd0;
			idle_ticks_q      <= 9'd0;
		end else if (is_tick) begin
			if (idle_ticks_q > {1'b0, timeout_limit}) begin
				byte_count_q <= 4'd0;
			end else begin
				idle_ticks_q <= idle_ticks_q + 9'd1;
			end
		end else if (is_byte) begin
			packet_type_q     <= type_d;
			expected_length_q <= len_d;
			byte_count_q      <= complete ? 4'd0 : count_d;
			if (begin_pkt) begin
				idle_ticks_q <= 9'd0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lgcp_engine.sv
// packet execution: buffer load, display read-modify-write and result register
`timescale 1ns / 1ps
`default_nettype none

module lgcp_engine import lgcp_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pkt_info_t                     pkt,
	input  logic [7:0]                    firmware_version,
	output logic                          busy,
	output logic                          pkt_rd_en,
	output logic [$clog2(MAX_PACKET)-1:0] pkt_rd_addr,
	input  logic [7:0]                    pkt_rd_data,
	output logic                          disp_rd_en,
	output logic [COL_W-1:0]              disp_rd_addr,
	input  logic [WORD_W-1:0]             disp_rd_data,
	output logic                          disp_we,
	output logic [COL_W-1:0]              disp_waddr,
	output logic [WORD_W-1:0]             disp_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [3:0]                    reg_addr,
	output logic [7:0]                    byte_a,
	output logic [7:0]                    byte_b,
	output logic [7:0]                    byte_c,
	output logic [7:0]                    byte_d,
	output logic                          last
);

	eng_state_t state_q, state_d;

	logic [3:0]       ptype_q;
	logic [3:0]       len_q;
	logic [3:0]       ld_cnt_q;
	logic             ld_pend_s1;
	logic [3:0]       ld_idx_s1;
	logic [2:0]       row_sel;
	logic [7:0]       b0_q;
	logic [7:0]       rows_q [NUM_COLS];
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] col_end_q;
	logic             rd_more_q;
	logic             col_pend_s1;
	logic [COL_W-1:0] wr_col_s1;
	logic             wr_last_s1;
	logic             misc_idx_q;
	logic             misc_two_q;

	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic [3:0]       reg_addr_q;
	logic [7:0]       byte_a_q, byte_b_q, byte_c_q, byte_d_q;
	logic             last_q;

	logic             out_free;
	logic             col_adv;
	logic             out_load;
	logic [2:0]       kind_d;
	logic [3:0]       reg_addr_d;
	logic [7:0]       byte_a_d, byte_b_d, byte_c_d, byte_d_d;
	logic             last_d;

	logic             go_cols, go_misc, misc_two;
	logic [COL_W-1:0] col_start, col_end;
	logic [7:0]       b1, b2;
	logic [7:0]       frame_byte;
	logic [3:0][7:0]  quad_new;

	logic [2:0]       misc_kind;
	logic [3:0]       misc_reg;
	logic [7:0]       misc_a, misc_b;

	assign b1       = rows_q[0];
	assign b2       = rows_q[1];
	assign row_sel  = ld_idx_s1[2:0] - 3'd1;
	assign out_free = !out_valid_q || out_ready;
	assign col_adv  = !col_pend_s1 || out_free;
	assign busy     = (state_q != ST_IDLE);

	// packet dispatch decode
	always_comb begin
		go_cols   = 1'b0;
		go_misc   = 1'b0;
		misc_two  = 1'b0;
		col_start = '0;
		col_end   = '1;
		case (ptype_q)
			PT_LED_ON, PT_LED_OFF: begin
				go_cols   = 1'b1;
				col_start = 3'd7 - b1[6:4];
				col_end   = 3'd7 - b1[6:4];
			end
			PT_ROW, PT_ROW2, PT_FRAME, PT_CLEAR: begin
				go_cols = 1'b1;
			end
			PT_COL, PT_COL2: begin
				go_cols   = 1'b1;
				col_start = b0_q[2:0];
				col_end   = b0_q[2:0];
			end
			PT_INTENSITY, PT_GRIDS: begin
				go_misc = 1'b1;
			end
			PT_MODE: begin
				go_misc  = (b0_q[1:0] != MODE_NONE);
				misc_two = 1'b1;
			end
			PT_AUX_IN: begin
				go_misc = (b0_q[3:0] == AUX_VERSION) || (b0_q[3:0] == AUX_PORT);
			end
			default: begin
			end
		endcase
	end

	// column modify
	always_comb begin
		for (int r = 0; r < NUM_COLS; r++) begin
			frame_byte[r] = rows_q[r][wr_col_s1];
		end
		quad_new = disp_rd_data;
		case (ptype_q)
			PT_LED_ON, PT_LED_OFF: begin
				quad_new[{b1[3], b1[7]}][b1[2:0]] = (ptype_q == PT_LED_ON);
			end
			PT_ROW, PT_ROW2: begin
				quad_new[{b0_q[3], 1'b0}][b0_q[2:0]] = b1[wr_col_s1];
				if (ptype_q == PT_ROW2) begin
					quad_new[{b0_q[3], 1'b1}][b0_q[2:0]] = b2[wr_col_s1];
				end
			end
			PT_COL, PT_COL2: begin
				quad_new[{1'b0, b0_q[3]}] = b1;
				if (ptype_q == PT_COL2) begin
					quad_new[{1'b1, b0_q[3]}] = b2;
				end
			end
			PT_FRAME: begin
				quad_new[b0_q[1:0]] = frame_byte;
			end
			PT_CLEAR: begin
				quad_new = {WORD_W{b0_q[0]}};
			end
			default: begin
			end
		endcase
	end

	// non-column results
	always_comb begin
		misc_kind = KIND_BCAST;
		misc_reg  = REG_NONE;
		misc_a    = 8'd0;
		misc_b    = 8'd0;
		case (ptype_q)
			PT_INTENSITY: begin
				misc_reg = REG_INTENSITY;
				misc_a   = {4'd0, b0_q[3:0]};
			end
			PT_MODE: begin
				if (!misc_idx_q) begin
					misc_reg = REG_SHUTDOWN;
					misc_a   = {7'd0, (b0_q[1:0] != MODE_OFF)};
				end else begin
					misc_reg = REG_TEST;
					misc_a   = {7'd0, (b0_q[1:0] == MODE_TEST)};
				end
			end
			PT_GRIDS: begin
				misc_kind = KIND_GRIDS;
				misc_a    = {4'd0, b0_q[3:0]};
			end
			PT_AUX_IN: begin
				if (b0_q[3:0] == AUX_VERSION) begin
					misc_kind = KIND_VERSION;
					misc_a    = REPLY_HDR;
					misc_b    = firmware_version;
				end else begin
					misc_kind = KIND_PORT;
					misc_a    = b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (col_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pkt.done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (ld_cnt_q == len_q) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (go_cols) begin
					state_d = ST_COLS;
				end else if (go_misc) begin
					state_d = ST_MISC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_COLS: begin
				if (col_adv && !rd_more_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_MISC: begin
				if (out_free && (misc_idx_q == misc_two_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pkt_rd_en    = 1'b0;
		pkt_rd_addr  = ld_cnt_q[$clog2(MAX_PACKET)-1:0];
		disp_rd_en   = 1'b0;
		disp_rd_addr = col_q;
		disp_we      = 1'b0;
		disp_waddr   = wr_col_s1;
		disp_wdata   = quad_new;
		out_load     = 1'b0;
		kind_d       = KIND_COLUMN;
		reg_addr_d   = {1'b0, wr_col_s1} + 4'd1;
		byte_a_d     = quad_new[0];
		byte_b_d     = quad_new[1];
		byte_c_d     = quad_new[2];
		byte_d_d     = quad_new[3];
		last_d       = wr_last_s1;
		case (state_q)
			ST_INIT: begin
				disp_we    = 1'b1;
				disp_waddr = col_q;
				disp_wdata = '0;
			end
			ST_LOAD: begin
				pkt_rd_en = (ld_cnt_q != len_q);
			end
			ST_COLS: begin
				disp_rd_en = col_adv && rd_more_q;
				if (col_pend_s1 && out_free) begin
					disp_we  = 1'b1;
					out_load = 1'b1;
				end
			end
			ST_MISC: begin
				out_load   = out_free;
				kind_d     = misc_kind;
				reg_addr_d = misc_reg;
				byte_a_d   = misc_a;
				byte_b_d   = misc_b;
				byte_c_d   = 8'd0;
				byte_d_d   = 8'd0;
				last_d     = (misc_idx_q == misc_two_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			ld_pend_s1  <= 1'b0;
			col_pend_s1 <= 1'b0;
			rd_more_q   <= 1'b0;
			misc_idx_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ld_pend_s1 <= pkt_rd_en;
			case (state_q)
				ST_INIT: begin
					col_q <= col_q + 1'b1;
				end
				ST_DISPATCH: begin
					col_q       <= col_start;
					rd_more_q   <= 1'b1;
					col_pend_s1 <= 1'b0;
					misc_idx_q  <= 1'b0;
				end
				ST_COLS: begin
					if (col_adv) begin
						col_pend_s1 <= rd_more_q;
						if (rd_more_q) begin
							if (col_q == col_end_q) begin
								rd_more_q <= 1'b0;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				ST_MISC: begin
					if (out_free) begin
						misc_idx_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ld_idx_s1 <= ld_cnt_q;
		if (state_q == ST_IDLE && pkt.done) begin
			ptype_q  <= pkt.ptype;
			len_q    <= pkt.length;
			ld_cnt_q <= 4'd0;
		end else if (pkt_rd_en) begin
			ld_cnt_q <= ld_cnt_q + 4'd1;
		end
		if (ld_pend_s1) begin
			if (ld_idx_s1 == 4'd0) begin
				b0_q <= pkt_rd_data;
			end else begin
				rows_q[row_sel] <= pkt_rd_data;
			end
		end
		if (state_q == ST_DISPATCH) begin
			col_end_q  <= col_end;
			misc_two_q <= misc_two;
		end
		if (state_q == ST_COLS && col_adv && rd_more_q) begin
			wr_col_s1  <= col_q;
			wr_last_s1 <= (col_q == col_end_q);
		end
		if (out_load) begin
			kind_q     <= kind_d;
			reg_addr_q <= reg_addr_d;
			byte_a_q   <= byte_a_d;
			byte_b_q   <= byte_b_d;
			byte_c_q   <= byte_c_d;
			byte_d_q   <= byte_d_d;
			last_q     <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign reg_addr  = reg_addr_q;
	assign byte_a    = byte_a_q;
	assign byte_b    = byte_b_q;
	assign byte_c    = byte_c_q;
	assign byte_d    = byte_d_q;
	assign last      = last_q;

endmodule

`default_nettype wire

FILE: rtl/led_grid_command_parser_top.sv
// led grid command parser: 8 x 32 bit column store, packet buffer, framing and execution
// a byte or tick is accepted while in_ready is high; a byte that completes a packet then
// reads the packet buffer in ST_LOAD and passes ST_DISPATCH; the first result is registered
// from ST_MISC for a broadcast or reply, or after a display read in ST_COLS for a column update,
// then one per cycle while results are taken; in_ready returns with the last result
// reset loads the register defaults, then ST_INIT clears all 8 display columns with in_ready low
`timescale 1ns / 1ps
`default_nettype none

module led_grid_command_parser_top import lgcp_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [3:0] reg_addr,
	output logic [7:0] byte_a,
	output logic [7:0] byte_b,
	output logic [7:0] byte_c,
	output logic [7:0] byte_d,
	output logic       last
);

	localparam int PIDX_W = $clog2(MAX_PACKET);

	logic [7:0]        timeout_limit_q;
	logic [7:0]        firmware_version_q;

	logic              busy;
	logic              accept;
	pkt_info_t         pkt;

	logic              pkt_we;
	logic [PIDX_W-1:0] pkt_waddr;
	logic [7:0]        pkt_wdata;
	logic              pkt_re;
	logic [PIDX_W-1:0] pkt_raddr;
	logic [7:0]        pkt_rdata;

	logic              disp_we;
	logic [COL_W-1:0]  disp_waddr;
	logic [WORD_W-1:0] disp_wdata;
	logic              disp_re;
	logic [COL_W-1:0]  disp_raddr;
	logic [WORD_W-1:0] disp_rdata;

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q    <= TIMEOUT_RST;
			firmware_version_q <= VERSION_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_limit_q    <= cfg_data;
				CFG_VERSION: firmware_version_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lgcp_assembler #(
		.MAX_PACKET(MAX_PACKET)
	) u_assembler (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.data_byte    (data_byte),
		.timeout_limit(timeout_limit_q),
		.pkt_we       (pkt_we),
		.pkt_waddr    (pkt_waddr),
		.pkt_wdata    (pkt_wdata),
		.pkt          (pkt)
	);

	lgcp_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PACKET)
	) u_pkt_ram (
		.clk    (clk),
		.wr_en  (pkt_we),
		.wr_addr(pkt_waddr),
		.wr_data(pkt_wdata),
		.rd_en  (pkt_re),
		.rd_addr(pkt_raddr),
		.rd_data(pkt_rdata)
	);

	lgcp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_COLS)
	) u_disp_ram (
		.clk    (clk),
		.wr_en  (disp_we),
		.wr_addr(disp_waddr),
		.wr_data(disp_wdata),
		.rd_en  (disp_re),
		.rd_addr(disp_raddr),
		.rd_data(disp_rdata)
	);

	lgcp_engine #(
		.MAX_PACKET(MAX_PACKET)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.pkt             (pkt),
		.firmware_version(firmware_version_q),
		.busy            (busy),
		.pkt_rd_en       (pkt_re),
		.pkt_rd_addr     (pkt_raddr),
		.pkt_rd_data     (pkt_rdata),
		.disp_rd_en      (disp_re),
		.disp_rd_addr    (disp_raddr),
		.disp_rd_data    (disp_rdata),
		.disp_we         (disp_we),
		.disp_waddr      (disp_waddr),
		.disp_wdata      (disp_wdata),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.reg_addr        (reg_addr),
		.byte_a          (byte_a),
		.byte_b          (byte_b),
		.byte_c          (byte_c),
		.byte_d          (byte_d),
		.last            (last)
	);

	// overlapped column pass never reads the column being written back
	assert property (@(posedge clk) disable iff (!arst_n)
		disp_we && disp_re |-> disp_waddr != disp_raddr)
		else $error("display read and write hit the same column");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_COLUMN |-> reg_addr != 4'd0 && reg_addr <= 4'd8)
		else $error("column update with bad column register");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BCAST |->
		reg_addr == REG_INTENSITY || reg_addr == REG_SHUTDOWN || reg_addr == REG_TEST)
		else $error("broadcast with bad driver register");

	assert property (@(posedge clk) disable iff (!arst_n)
		pkt.done |-> accept && command == CMD_BYTE)
		else $error("packet completed without a byte transaction");

endmodule

`default_nettype wire
